### hw/rtl/zsd_pkg.sv
package zsd_pkg;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_STRAIGHT = 3'd1,
        ACT_RIGHT1   = 3'd2,
        ACT_RIGHT2   = 3'd3,
        ACT_RIGHT3   = 3'd4,
        ACT_LEFT1    = 3'd5,
        ACT_LEFT2    = 3'd6,
        ACT_LEFT3    = 3'd7
    } action_t;

    localparam int XW    = 12;
    localparam int TRIMW = 13;
    localparam int DUTYW = 8;
    localparam int TIMEW = 16;

    typedef logic signed [XW-1:0]    pos_t;
    typedef logic signed [TRIMW-1:0] trim_t;

    // register indexes on the config port
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_PULSE  = 2'd1;
    localparam logic [1:0] REG_PAUSE  = 2'd2;

    // zone edges in pixels
    localparam pos_t X_STRAIGHT_LO = 12'sd270;
    localparam pos_t X_STRAIGHT_HI = 12'sd370;
    localparam pos_t X_RIGHT2_LO   = 12'sd470;
    localparam pos_t X_RIGHT3_LO   = 12'sd600;
    localparam pos_t X_MAX         = 12'sd640;
    localparam pos_t X_LEFT1_LO    = 12'sd170;
    localparam pos_t X_LEFT3_HI    = 12'sd40;

    localparam logic [DUTYW-1:0] DUTY_BASE  = 8'd75;
    localparam logic [DUTYW-1:0] DUTY_LOW   = 8'd55;
    localparam logic [DUTYW-1:0] DUTY_MID   = 8'd83;
    localparam logic [DUTYW-1:0] DUTY_HIGH  = 8'd95;
    localparam logic [DUTYW-1:0] DUTY_LOW3  = 8'd60;

    // trims in units of 0.05
    localparam trim_t TRIM_ONE   = 13'sd5;
    localparam trim_t TRIM_TWO   = 13'sd7;
    localparam trim_t TRIM_THREE = 13'sd16;
    localparam trim_t TRIM_CLAMP = 13'sd400;
    localparam trim_t TRIM_DECAY = 13'sd40;
    localparam trim_t TRIM_SAT   = 13'sd2500;
    localparam trim_t TRIM_MIN   = -13'sd39;
    // 75 duty expressed in trim units
    localparam logic signed [TRIMW:0] DUTY_BASE_UNITS = 14'sd1500;
    // floor(n/5) == (n*205)>>10 for n below 1024
    localparam logic [7:0] RECIP5 = 8'd205;

    typedef struct packed {
        action_t           action;
        logic [DUTYW-1:0]  left_duty;
        logic [DUTYW-1:0]  right_duty;
        logic [TIMEW-1:0]  on_time;
        logic [TIMEW-1:0]  off_time;
    } res_t;

endpackage

### hw/rtl/zsd_zone.sv
module zsd_zone (
    input  zsd_pkg::pos_t              x,
    input  logic                       enable,
    input  logic [zsd_pkg::TIMEW-1:0]  pulse_time,
    input  logic [zsd_pkg::TIMEW-1:0]  pause_time,
    input  zsd_pkg::trim_t             left_trim,
    input  zsd_pkg::trim_t             right_trim,
    output zsd_pkg::res_t              res,
    output zsd_pkg::trim_t             left_trim_next,
    output zsd_pkg::trim_t             right_trim_next
);

    function automatic zsd_pkg::trim_t trim_add(zsd_pkg::trim_t t, zsd_pkg::trim_t inc);
        logic signed [zsd_pkg::TRIMW:0] s;
        s = {t[zsd_pkg::TRIMW-1], t} + {inc[zsd_pkg::TRIMW-1], inc};
        // signed compare: a trim left negative by the straight decrement must not saturate
        if (s > $signed({1'b0, zsd_pkg::TRIM_SAT}))
            return zsd_pkg::TRIM_SAT;
        return s[zsd_pkg::TRIMW-1:0];
    endfunction

    function automatic zsd_pkg::trim_t trim_settle(zsd_pkg::trim_t t);
        zsd_pkg::trim_t c;
        c = (t > zsd_pkg::TRIM_CLAMP) ? zsd_pkg::TRIM_CLAMP : t;
        return (c > 13'sd0) ? c - zsd_pkg::TRIM_DECAY : 13'sd0;
    endfunction

    // (1500 + t) / 20: total always lies in 1461..4000, so drop two bits and divide by 5
    function automatic logic [zsd_pkg::DUTYW-1:0] straight_duty(zsd_pkg::trim_t t);
        logic signed [zsd_pkg::TRIMW:0] total;
        logic [17:0]                    prod;
        total = zsd_pkg::DUTY_BASE_UNITS + {t[zsd_pkg::TRIMW-1], t};
        prod  = {8'd0, total[11:2]} * {10'd0, zsd_pkg::RECIP5};
        return prod[17:10];
    endfunction

    logic [zsd_pkg::TIMEW-1:0] half_pulse;
    assign half_pulse = {1'b0, pulse_time[zsd_pkg::TIMEW-1:1]};

    always_comb
    begin
        res             = '0;
        res.action      = zsd_pkg::ACT_NONE;
        left_trim_next  = left_trim;
        right_trim_next = right_trim;
        if (enable)
        begin
            if (x >= zsd_pkg::X_STRAIGHT_LO && x <= zsd_pkg::X_STRAIGHT_HI)
            begin
                res.action      = zsd_pkg::ACT_STRAIGHT;
                res.left_duty   = straight_duty(left_trim);
                res.right_duty  = straight_duty(right_trim);
                left_trim_next  = trim_settle(left_trim);
                right_trim_next = trim_settle(right_trim);
            end
            else if (x > zsd_pkg::X_STRAIGHT_HI && x < zsd_pkg::X_RIGHT2_LO)
            begin
                res.action      = zsd_pkg::ACT_RIGHT1;
                res.left_duty   = zsd_pkg::DUTY_BASE;
                res.right_duty  = zsd_pkg::DUTY_LOW;
                res.on_time     = pulse_time;
                res.off_time    = pause_time;
                right_trim_next = trim_add(right_trim, zsd_pkg::TRIM_ONE);
            end
            else if (x >= zsd_pkg::X_RIGHT2_LO && x < zsd_pkg::X_RIGHT3_LO)
            begin
                res.action      = zsd_pkg::ACT_RIGHT2;
                res.left_duty   = zsd_pkg::DUTY_MID;
                res.right_duty  = zsd_pkg::DUTY_LOW;
                res.on_time     = pulse_time;
                res.off_time    = pause_time;
                right_trim_next = trim_add(right_trim, zsd_pkg::TRIM_TWO);
            end
            else if (x >= zsd_pkg::X_RIGHT3_LO && x <= zsd_pkg::X_MAX)
            begin
                res.action      = zsd_pkg::ACT_RIGHT3;
                res.left_duty   = zsd_pkg::DUTY_HIGH;
                res.right_duty  = zsd_pkg::DUTY_LOW3;
                res.on_time     = half_pulse;
                res.off_time    = pause_time;
                right_trim_next = trim_add(right_trim, zsd_pkg::TRIM_THREE);
            end
            else if (x < zsd_pkg::X_STRAIGHT_LO && x > zsd_pkg::X_LEFT1_LO)
            begin
                res.action     = zsd_pkg::ACT_LEFT1;
                res.left_duty  = zsd_pkg::DUTY_LOW;
                res.right_duty = zsd_pkg::DUTY_BASE;
                res.on_time    = pulse_time;
                res.off_time   = pause_time;
                left_trim_next = trim_add(left_trim, zsd_pkg::TRIM_ONE);
            end
            else if (x <= zsd_pkg::X_LEFT1_LO && x >= zsd_pkg::X_LEFT3_HI)
            begin
                res.action     = zsd_pkg::ACT_LEFT2;
                res.left_duty  = zsd_pkg::DUTY_LOW;
                res.right_duty = zsd_pkg::DUTY_MID;
                res.on_time    = pulse_time;
                res.off_time   = pause_time;
                left_trim_next = trim_add(left_trim, zsd_pkg::TRIM_TWO);
            end
            else if (x < zsd_pkg::X_LEFT3_HI && x >= 12'sd0)
            begin
                res.action     = zsd_pkg::ACT_LEFT3;
                res.left_duty  = zsd_pkg::DUTY_LOW3;
                res.right_duty = zsd_pkg::DUTY_HIGH;
                res.on_time    = half_pulse;
                res.off_time   = pause_time;
                left_trim_next = trim_add(left_trim, zsd_pkg::TRIM_THREE);
            end
        end
    end

endmodule

### hw/rtl/zone_steering_drive.sv
// Channel   Dir  Handshake                        Payload
// s_axis    in   s_axis_tvalid / s_axis_tready    target_x in tdata[11:0]
// m_axis    out  m_axis_tvalid / m_axis_tready    action, duties, on/off times
// cfg       in   cfg_valid / cfg_ready            cfg_index, cfg_data
//
// One word per cycle sustained unless the output stalls; a word passes the
// input register, then the result register. Zone decode and trim update sit
// between the two. Trims update as a word moves into the result register, so
// the next word already sees them. rst_n clears config, trims and valid flags.
// A stalled output still lets one more word sit in the input register.
module zone_steering_drive (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [11:0] target_x
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,   // [2:0] action, [10:3] left_duty,
                                        // [18:11] right_duty, [34:19] on_time,
                                        // [50:35] off_time
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic                       enable_reg;
    logic [zsd_pkg::TIMEW-1:0]  pulse_reg;
    logic [zsd_pkg::TIMEW-1:0]  pause_reg;
    zsd_pkg::trim_t             left_trim_reg;
    zsd_pkg::trim_t             right_trim_reg;
    zsd_pkg::trim_t             left_trim_next;
    zsd_pkg::trim_t             right_trim_next;
    logic                       in_valid_reg;
    zsd_pkg::pos_t              x_reg;
    logic                       out_valid_reg;
    zsd_pkg::res_t              out_reg;
    zsd_pkg::res_t              res_next;
    logic                       advance;
    logic                       cfg_we;

    assign cfg_ready     = 1'b1;
    assign cfg_we        = cfg_valid && cfg_ready;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.off_time, out_reg.on_time,
                            out_reg.right_duty, out_reg.left_duty, out_reg.action};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            pulse_reg  <= '0;
            pause_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                zsd_pkg::REG_ENABLE: enable_reg <= cfg_data[0];
                zsd_pkg::REG_PULSE:  pulse_reg  <= cfg_data;
                zsd_pkg::REG_PAUSE:  pause_reg  <= cfg_data;
                default:             ;
            endcase
        end
    end

    zsd_zone u_zone (
        .x               (x_reg),
        .enable          (enable_reg),
        .pulse_time      (pulse_reg),
        .pause_time      (pause_reg),
        .left_trim       (left_trim_reg),
        .right_trim      (right_trim_reg),
        .res             (res_next),
        .left_trim_next  (left_trim_next),
        .right_trim_next (right_trim_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            left_trim_reg  <= '0;
            right_trim_reg <= '0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                left_trim_reg  <= left_trim_next;
                right_trim_reg <= right_trim_next;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            x_reg <= s_axis_tdata[zsd_pkg::XW-1:0];
        if (advance)
            out_reg <= res_next;
    end

    a_trim_range: assert property (@(posedge clk) disable iff (!rst_n)
        left_trim_reg <= zsd_pkg::TRIM_SAT && left_trim_reg >= zsd_pkg::TRIM_MIN &&
        right_trim_reg <= zsd_pkg::TRIM_SAT && right_trim_reg >= zsd_pkg::TRIM_MIN)
        else $error("trim left its reachable range");

    a_trim_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(left_trim_reg) && $stable(right_trim_reg))
        else $error("trim changed without a word moving on");

    a_none_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.action == zsd_pkg::ACT_NONE |->
        out_reg.left_duty == '0 && out_reg.right_duty == '0 &&
        out_reg.on_time == '0 && out_reg.off_time == '0)
        else $error("no-action word carries drive values");

    a_straight_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.action == zsd_pkg::ACT_STRAIGHT |->
        out_reg.on_time == '0 && out_reg.off_time == '0 &&
        out_reg.left_duty <= 8'd200 && out_reg.right_duty <= 8'd200)
        else $error("straight word with pulse timing or duty over 200");

endmodule
